// ===== rtl/core/rde_pkg.sv =====
// ----------------------------------------------------------------------------
// rde_pkg
// Shared types and codes of the ring deque engine: payload structs, request
// codes, result status codes and the controller-to-datapath action set.
// ----------------------------------------------------------------------------
`default_nettype none

package rde_pkg;

	// fixed field widths of the request and response items
	localparam int TYPE_W = 4;
	localparam int DIN_W  = 64;
	localparam int OFF_W  = 10;
	localparam int DOUT_W = 64;
	localparam int LEN_W  = 11;
	localparam int CAP_W  = 11;

	// request codes
	typedef enum logic [TYPE_W-1:0] {
		REQ_PUSH_FRONT = 4'd0,
		REQ_POP_FRONT  = 4'd1,
		REQ_READ_FRONT = 4'd2,
		REQ_WRITE_FRONT = 4'd3,
		REQ_PUSH_BACK  = 4'd4,
		REQ_POP_BACK   = 4'd5,
		REQ_READ_BACK  = 4'd6,
		REQ_WRITE_BACK = 4'd7,
		REQ_CLEAR      = 4'd8
	} req_code_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

	// datapath action chosen by the controller
	typedef enum logic [3:0] {
		ACT_NONE    = 4'd0,
		ACT_PUSH_F  = 4'd1,
		ACT_POP_F   = 4'd2,
		ACT_READ_F  = 4'd3,
		ACT_WRITE_F = 4'd4,
		ACT_PUSH_B  = 4'd5,
		ACT_POP_B   = 4'd6,
		ACT_READ_B  = 4'd7,
		ACT_WRITE_B = 4'd8,
		ACT_CLEAR   = 4'd9
	} act_t;

	// request item
	typedef struct packed {
		logic [TYPE_W-1:0] req_type;
		logic [DIN_W-1:0]  data_in;
		logic [OFF_W-1:0]  offset;
	} req_t;

	// response item
	typedef struct packed {
		logic [DOUT_W-1:0] data_out;
		status_t           status;
		logic [LEN_W-1:0]  length;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic    capture;
		logic    cfg_wr;
		logic    exec;
		act_t    act;
		status_t stat;
		logic    load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		req_code_t op;
		logic      empty;
		logic      full;
		logic      in_range;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/ring_deque_engine_unit.sv =====
// ----------------------------------------------------------------------------
// ring_deque_engine_unit
// Double-ended queue over a circular single-port store with indexed access.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req) carries one request item: push or
//   pop at either end, read or write at an offset from either end, or clear.
//   rsp channel (rsp_valid/rsp_stall/rsp) returns exactly one item per
//   request with data, status and the length after the request.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes the capacity in use
//   (zero acts as 1, above DEPTH acts as DEPTH) and empties the queue; it
//   is taken only between requests and wins over a request in the same cycle.
//   Timing: a request is accepted, executes against the store in the next
//   cycle, and its response is then registered once the response register
//   is free. One request is in flight at a time: a new one is accepted only
//   after the previous one has executed and its response has been loaded.
//   If the receiver stalls, the response holds and the block waits before
//   loading the next one; a request can still be accepted while a finished
//   response waits.
//   Reset empties the queue and sets the capacity to DEPTH (low 11 bits,
//   or 1 if zero); store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_deque_engine_unit #(
	parameter int DEPTH      = 1024,
	parameter int DATA_WIDTH = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      req_valid,
	output logic                           req_stall,
	input  wire rde_pkg::req_t             req,
	output logic                           rsp_valid,
	input  wire logic                      rsp_stall,
	output rde_pkg::rsp_t                  rsp,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [rde_pkg::CAP_W-1:0] cfg_data
);

	rde_pkg::cmd_t cmd;
	rde_pkg::sts_t sts;

	// sequencer
	rde_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// store, pointers and response register
	rde_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire

// ===== rtl/core/rde_ctrl.sv =====
// ----------------------------------------------------------------------------
// rde_ctrl
// Sequencer of the ring deque engine: takes one item at a time, decodes the
// held request against the queue flags and steers the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module rde_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire logic           rsp_stall,
	output logic                rsp_valid,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire rde_pkg::sts_t  sts,
	output rde_pkg::cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   rsp_valid_q;
	logic   idle;
	logic   take;
	logic   rsp_free;
	logic   load;
	rde_pkg::act_t    act;
	rde_pkg::status_t stat;

	// handshake decisions
	assign idle      = (state_q == ST_IDLE);
	assign cfg_ready = idle;
	assign req_stall = !idle || cfg_valid;
	assign take      = idle && req_valid && !cfg_valid;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign load      = (state_q == ST_FIN) && rsp_free;
	assign rsp_valid = rsp_valid_q;

	// request decode against the queue flags
	always_comb begin
		act  = rde_pkg::ACT_NONE;
		stat = rde_pkg::STAT_OK;
		unique case (sts.op)
			rde_pkg::REQ_PUSH_FRONT, rde_pkg::REQ_PUSH_BACK: begin
				if (sts.full) begin
					stat = rde_pkg::STAT_FULL;
				end else if (sts.op == rde_pkg::REQ_PUSH_FRONT) begin
					act = rde_pkg::ACT_PUSH_F;
				end else begin
					act = rde_pkg::ACT_PUSH_B;
				end
			end
			rde_pkg::REQ_POP_FRONT, rde_pkg::REQ_POP_BACK: begin
				if (sts.empty) begin
					stat = rde_pkg::STAT_EMPTY;
				end else if (sts.op == rde_pkg::REQ_POP_FRONT) begin
					act = rde_pkg::ACT_POP_F;
				end else begin
					act = rde_pkg::ACT_POP_B;
				end
			end
			rde_pkg::REQ_READ_FRONT, rde_pkg::REQ_WRITE_FRONT,
			rde_pkg::REQ_READ_BACK, rde_pkg::REQ_WRITE_BACK: begin
				priority if (sts.empty) begin
					stat = rde_pkg::STAT_EMPTY;
				end else if (!sts.in_range) begin
					stat = rde_pkg::STAT_RANGE;
				end else begin
					unique case (sts.op)
						rde_pkg::REQ_READ_FRONT:  act = rde_pkg::ACT_READ_F;
						rde_pkg::REQ_WRITE_FRONT: act = rde_pkg::ACT_WRITE_F;
						rde_pkg::REQ_READ_BACK:   act = rde_pkg::ACT_READ_B;
						default:                  act = rde_pkg::ACT_WRITE_B;
					endcase
				end
			end
			rde_pkg::REQ_CLEAR: act = rde_pkg::ACT_CLEAR;
			default: begin
			end
		endcase
	end

	// command bundle
	always_comb begin
		cmd.capture = take;
		cmd.cfg_wr  = cfg_valid && cfg_ready;
		cmd.exec    = (state_q == ST_EXEC);
		cmd.act     = act;
		cmd.stat    = stat;
		cmd.load    = load;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (take) state_nxt = ST_EXEC;
			ST_EXEC: state_nxt = ST_FIN;
			ST_FIN:  if (rsp_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// state and response valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rde_datapath.sv =====
// ----------------------------------------------------------------------------
// rde_datapath
// Circular element store with front and back pointers, element count,
// capacity register, held request and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module rde_datapath #(
	parameter int DEPTH      = 1024,
	parameter int DATA_WIDTH = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire rde_pkg::req_t               req,
	input  wire logic [rde_pkg::CAP_W-1:0]   cfg_data,
	input  wire rde_pkg::cmd_t               cmd,
	output rde_pkg::sts_t                    sts,
	output rde_pkg::rsp_t                    rsp
);

	localparam int AW      = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int CW      = (CNT_W > rde_pkg::CAP_W) ? CNT_W : rde_pkg::CAP_W;
	localparam int SW      = CW + 1;
	localparam int RST_RAW = DEPTH % (2 ** rde_pkg::CAP_W);
	localparam int RST_CAP = (RST_RAW == 0) ? 1 : RST_RAW;

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	// held request
	logic [rde_pkg::TYPE_W-1:0] op_q;
	logic [DATA_WIDTH-1:0]      data_q;
	logic [rde_pkg::OFF_W-1:0]  off_q;

	// queue state
	logic [AW-1:0]    front_q;
	logic [AW-1:0]    back_q;
	logic [CNT_W-1:0] count_q;
	logic [CW-1:0]    cap_q;

	// result of the executed request
	rde_pkg::status_t stat_q;
	logic             rd_q;
	rde_pkg::rsp_t    rsp_q;

	logic [CW-1:0] cap_new;
	logic [SW-1:0] front_x, back_x, cap_x, off_x, cnt_x;
	logic [SW-1:0] front_dec, front_inc, back_dec, back_inc;
	logic [SW-1:0] idx_f_raw, idx_b_raw, idx_f, idx_b;
	logic [SW-1:0] addr_x;
	logic          mem_we, mem_re;

	// capacity as written, held within 1..DEPTH
	always_comb begin
		priority if (cfg_data == '0) begin
			cap_new = CW'(1);
		end else if (CW'(cfg_data) > CW'(DEPTH)) begin
			cap_new = CW'(DEPTH);
		end else begin
			cap_new = CW'(cfg_data);
		end
	end

	// pointer arithmetic, all wrapping at the capacity in use
	always_comb begin
		front_x   = SW'(front_q);
		back_x    = SW'(back_q);
		cap_x     = SW'(cap_q);
		off_x     = SW'(off_q);
		cnt_x     = SW'(count_q);
		front_dec = (front_x == '0) ? cap_x - SW'(1) : front_x - SW'(1);
		front_inc = (front_x + SW'(1) >= cap_x) ? '0 : front_x + SW'(1);
		back_dec  = (back_x == '0) ? cap_x - SW'(1) : back_x - SW'(1);
		back_inc  = (back_x + SW'(1) >= cap_x) ? '0 : back_x + SW'(1);
		idx_f_raw = front_x + off_x;
		idx_f     = (idx_f_raw >= cap_x) ? idx_f_raw - cap_x : idx_f_raw;
		idx_b_raw = back_x + cap_x - off_x - SW'(1);
		idx_b     = (idx_b_raw >= cap_x) ? idx_b_raw - cap_x : idx_b_raw;
	end

	// store address and enables for the chosen action
	always_comb begin
		addr_x = '0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		unique case (cmd.act)
			rde_pkg::ACT_PUSH_F:  begin addr_x = front_dec; mem_we = cmd.exec; end
			rde_pkg::ACT_POP_F:   begin addr_x = front_x;   mem_re = cmd.exec; end
			rde_pkg::ACT_READ_F:  begin addr_x = idx_f;     mem_re = cmd.exec; end
			rde_pkg::ACT_WRITE_F: begin addr_x = idx_f;     mem_we = cmd.exec; end
			rde_pkg::ACT_PUSH_B:  begin addr_x = back_x;    mem_we = cmd.exec; end
			rde_pkg::ACT_POP_B:   begin addr_x = back_dec;  mem_re = cmd.exec; end
			rde_pkg::ACT_READ_B:  begin addr_x = idx_b;     mem_re = cmd.exec; end
			rde_pkg::ACT_WRITE_B: begin addr_x = idx_b;     mem_we = cmd.exec; end
			rde_pkg::ACT_NONE, rde_pkg::ACT_CLEAR: begin
			end
			default: begin
			end
		endcase
	end

	// single-port element store with registered read data
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_x[AW-1:0]] <= data_q;
		end
		if (mem_re) begin
			rdata_q <= mem[addr_x[AW-1:0]];
		end
	end

	// request capture and result holding
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= req.req_type;
			data_q <= req.data_in[DATA_WIDTH-1:0];
			off_q  <= req.offset;
		end
		if (cmd.exec) begin
			stat_q <= cmd.stat;
			rd_q   <= (cmd.act == rde_pkg::ACT_POP_F) || (cmd.act == rde_pkg::ACT_POP_B) ||
			          (cmd.act == rde_pkg::ACT_READ_F) || (cmd.act == rde_pkg::ACT_READ_B);
		end
		if (cmd.load) begin
			rsp_q.data_out <= rd_q ? rde_pkg::DOUT_W'(rdata_q) : '0;
			rsp_q.status   <= stat_q;
			rsp_q.length   <= rde_pkg::LEN_W'(count_q);
		end
	end

	// pointers, count and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
			cap_q   <= CW'(RST_CAP);
		end else if (cmd.cfg_wr) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
			cap_q   <= cap_new;
		end else if (cmd.exec) begin
			unique case (cmd.act)
				rde_pkg::ACT_PUSH_F: begin
					front_q <= front_dec[AW-1:0];
					count_q <= count_q + CNT_W'(1);
				end
				rde_pkg::ACT_PUSH_B: begin
					back_q  <= back_inc[AW-1:0];
					count_q <= count_q + CNT_W'(1);
				end
				rde_pkg::ACT_POP_F: begin
					front_q <= front_inc[AW-1:0];
					count_q <= count_q - CNT_W'(1);
				end
				rde_pkg::ACT_POP_B: begin
					back_q  <= back_dec[AW-1:0];
					count_q <= count_q - CNT_W'(1);
				end
				rde_pkg::ACT_CLEAR: begin
					front_q <= '0;
					back_q  <= '0;
					count_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// flags for the controller
	always_comb begin
		sts.op       = rde_pkg::req_code_t'(op_q);
		sts.empty    = (count_q == '0);
		sts.full     = (cnt_x >= cap_x);
		sts.in_range = (off_x < cnt_x);
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/core/rde_checker.sv =====
// ----------------------------------------------------------------------------
// rde_checker
// Port-level checks of the ring deque engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rde_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire rde_pkg::rsp_t rsp
);

	// a stalled response holds
	ast_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// one request in flight: no acceptance right after an acceptance
	ast_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while one is in flight");

	// an empty status only comes with an empty queue
	ast_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == rde_pkg::STAT_EMPTY) |-> rsp.length == '0)
		else $error("empty status with nonzero length");

	// failed requests carry zero data
	ast_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != rde_pkg::STAT_OK) |-> rsp.data_out == '0)
		else $error("failed request returned data");

endmodule

bind ring_deque_engine_unit rde_checker u_rde_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire

// ===== tb/ring_deque_engine_unit_tb.sv =====
// ----------------------------------------------------------------------------
// ring_deque_engine_unit_tb
// Self-checking bench for the ring deque engine. A directed table exercises
// empty, full, out-of-range, clear and capacity corner cases. Random request
// mixes then run under several capacities, with random idling on both sides,
// a receiver hold-off and drains before every capacity write. Each response
// item is checked field by field against its table row or a deque predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_deque_engine_unit_tb;

	localparam int DEPTH          = 1024;
	localparam int DATA_WIDTH     = 64;
	localparam int STALL_HOLD     = 200;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int PHASES         = 10;
	localparam int PHASE_ITEMS    = 100;

	logic                      clk;
	logic                      arst_n;
	logic                      req_valid;
	logic                      req_stall;
	rde_pkg::req_t             req;
	logic                      rsp_valid;
	logic                      rsp_stall;
	rde_pkg::rsp_t             rsp;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [rde_pkg::CAP_W-1:0] cfg_data;

	// one row of the directed table: a capacity write or a request item
	typedef struct {
		bit                        is_cfg;
		logic [rde_pkg::CAP_W-1:0] cap_val;
		rde_pkg::req_t             item;
		bit                        typed;
		rde_pkg::rsp_t             want;
	} dir_row_t;

	dir_row_t      dir_rows[$];
	rde_pkg::rsp_t awaited_responses[$];

	// shadow deque state
	logic [DATA_WIDTH-1:0]     shadow_mem [DEPTH];
	int unsigned               shadow_front;
	int unsigned               shadow_back;
	int unsigned               shadow_count;
	logic [rde_pkg::CAP_W-1:0] shadow_cap;

	// run bookkeeping
	int  error_count;
	int  sent_count;
	int  directed_count;
	int  checked_count;
	int  cfg_count;
	int  full_seen;
	int  empty_seen;
	int  range_seen;
	int  idle_cycles;
	int  hold_asked;
	int  hold_served;
	int  hold_left;
	bit  quiet;

	ring_deque_engine_unit #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// clock, period 4
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// zero acts as one entry, anything above the store size as the full store
	function automatic int unsigned effective_capacity();
		if (shadow_cap == '0) return 1;
		if (shadow_cap > rde_pkg::CAP_W'(DEPTH)) return DEPTH;
		return int'(shadow_cap);
	endfunction

	// apply one request to the shadow deque and return its response item
	function automatic rde_pkg::rsp_t compute_deque_response(rde_pkg::req_t item);
		rde_pkg::rsp_t      res;
		int unsigned        cap;
		int unsigned        pos;
		rde_pkg::req_code_t code;
		cap          = effective_capacity();
		code         = rde_pkg::req_code_t'(item.req_type);
		res.data_out = '0;
		res.status   = rde_pkg::STAT_OK;
		case (code)
			rde_pkg::REQ_PUSH_FRONT, rde_pkg::REQ_PUSH_BACK: begin
				if (shadow_count >= cap) begin
					res.status = rde_pkg::STAT_FULL;
				end else if (code == rde_pkg::REQ_PUSH_FRONT) begin
					shadow_front = (shadow_front == 0) ? cap - 1 : shadow_front - 1;
					shadow_mem[shadow_front] = item.data_in;
					shadow_count++;
				end else begin
					shadow_mem[shadow_back] = item.data_in;
					shadow_back = (shadow_back + 1 >= cap) ? 0 : shadow_back + 1;
					shadow_count++;
				end
			end
			rde_pkg::REQ_POP_FRONT, rde_pkg::REQ_POP_BACK: begin
				if (shadow_count == 0) begin
					res.status = rde_pkg::STAT_EMPTY;
				end else if (code == rde_pkg::REQ_POP_FRONT) begin
					res.data_out = shadow_mem[shadow_front];
					shadow_front = (shadow_front + 1 >= cap) ? 0 : shadow_front + 1;
					shadow_count--;
				end else begin
					shadow_back  = (shadow_back == 0) ? cap - 1 : shadow_back - 1;
					res.data_out = shadow_mem[shadow_back];
					shadow_count--;
				end
			end
			rde_pkg::REQ_READ_FRONT, rde_pkg::REQ_WRITE_FRONT,
			rde_pkg::REQ_READ_BACK, rde_pkg::REQ_WRITE_BACK: begin
				if (shadow_count == 0) begin
					res.status = rde_pkg::STAT_EMPTY;
				end else if (item.offset >= shadow_count) begin
					res.status = rde_pkg::STAT_RANGE;
				end else begin
					if (code == rde_pkg::REQ_READ_FRONT ||
							code == rde_pkg::REQ_WRITE_FRONT)
						pos = shadow_front + item.offset;
					else
						pos = shadow_back + cap - item.offset - 1;
					if (pos >= cap) pos -= cap;
					if (code == rde_pkg::REQ_READ_FRONT ||
							code == rde_pkg::REQ_READ_BACK)
						res.data_out = shadow_mem[pos];
					else
						shadow_mem[pos] = item.data_in;
				end
			end
			rde_pkg::REQ_CLEAR: begin
				shadow_front = 0;
				shadow_back  = 0;
				shadow_count = 0;
			end
			default: ;
		endcase
		res.length = rde_pkg::LEN_W'(shadow_count);
		return res;
	endfunction

	// directed table builders
	task automatic add_op(input rde_pkg::req_code_t code,
			input logic [rde_pkg::DIN_W-1:0] d, input logic [rde_pkg::OFF_W-1:0] off);
		dir_row_t row;
		row.is_cfg       = 1'b0;
		row.cap_val      = '0;
		row.item.req_type = code;
		row.item.data_in  = d;
		row.item.offset   = off;
		row.typed        = 1'b0;
		row.want         = '0;
		dir_rows.push_back(row);
	endtask

	task automatic add_chk(input rde_pkg::req_code_t code,
			input logic [rde_pkg::DIN_W-1:0] d, input logic [rde_pkg::OFF_W-1:0] off,
			input rde_pkg::status_t st, input logic [rde_pkg::DOUT_W-1:0] dout,
			input int len);
		add_op(code, d, off);
		dir_rows[$].typed         = 1'b1;
		dir_rows[$].want.data_out = dout;
		dir_rows[$].want.status   = st;
		dir_rows[$].want.length   = rde_pkg::LEN_W'(len);
	endtask

	task automatic add_cfg(input logic [rde_pkg::CAP_W-1:0] v);
		dir_row_t row;
		row.is_cfg  = 1'b1;
		row.cap_val = v;
		row.item    = '0;
		row.typed   = 1'b0;
		row.want    = '0;
		dir_rows.push_back(row);
	endtask

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp);
		$display("mismatch %s at result %0d: got %0h expected %0h",
			what, checked_count, got, exp);
		error_count++;
	endtask

	// offer one request item, with a random gap ahead of it
	task automatic send_request(input rde_pkg::req_t item, input bit typed,
			input rde_pkg::rsp_t want);
		int            gap;
		rde_pkg::rsp_t pred;
		gap = 0;
		if (!quiet)
			while ($urandom_range(0, 99) < 28) gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (req_stall);
		pred = compute_deque_response(item);
		awaited_responses.push_back(typed ? want : pred);
		sent_count++;
	endtask

	// stop offering and wait until every response item is back
	task automatic drain_responses();
		req_valid <= 1'b0;
		while (awaited_responses.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// capacity write, only on an idle block
	task automatic write_capacity(input logic [rde_pkg::CAP_W-1:0] v);
		drain_responses();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid    <= 1'b0;
		shadow_cap   = v;
		shadow_front = 0;
		shadow_back  = 0;
		shadow_count = 0;
		cfg_count++;
	endtask

	// response checker
	always @(posedge clk) begin
		rde_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_responses.size() == 0) begin
				flag_mismatch("unexpected result", rsp.data_out, '0);
			end else begin
				want = awaited_responses.pop_front();
				if (rsp.data_out !== want.data_out)
					flag_mismatch("data_out", rsp.data_out, want.data_out);
				if (rsp.status !== want.status)
					flag_mismatch("status", 64'(rsp.status), 64'(want.status));
				if (rsp.length !== want.length)
					flag_mismatch("length", 64'(rsp.length), 64'(want.length));
				if (want.status == rde_pkg::STAT_FULL) full_seen++;
				if (want.status == rde_pkg::STAT_EMPTY) empty_seen++;
				if (want.status == rde_pkg::STAT_RANGE) range_seen++;
			end
			checked_count++;
		end
	end

	// receiver stall: random, or a counted hold-off when one is asked for
	always @(posedge clk) begin
		if (hold_asked != hold_served) begin
			rsp_stall <= 1'b1;
			hold_left++;
			if (hold_left == STALL_HOLD) begin
				hold_left = 0;
				hold_served++;
			end
		end else begin
			rsp_stall <= !quiet && ($urandom_range(0, 99) < 28);
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d results pending",
					idle_cycles, awaited_responses.size());
				$display("ring_deque_engine_unit regression: fail");
				$finish;
			end
		end
	end

	initial begin
		int                              ph;
		int                              n;
		int                              r;
		int                              push_pct;
		int                              pop_pct;
		int                              phase_caps[PHASES];
		rde_pkg::req_code_t              code;
		logic [rde_pkg::DIN_W-1:0]       d;
		logic [rde_pkg::OFF_W-1:0]       off;
		rde_pkg::req_t                   item;
		rde_pkg::rsp_t                   no_rsp;

		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req         = '0;
		rsp_stall   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		quiet       = 1'b0;
		hold_asked  = 0;
		hold_served = 0;
		hold_left   = 0;
		idle_cycles = 0;
		no_rsp      = '0;

		shadow_cap   = rde_pkg::CAP_W'(DEPTH);
		shadow_front = 0;
		shadow_back  = 0;
		shadow_count = 0;

		// empty queue after reset: every access fails
		add_chk(rde_pkg::REQ_POP_FRONT, '0, '0, rde_pkg::STAT_EMPTY, '0, 0);
		add_chk(rde_pkg::REQ_POP_BACK, '0, '0, rde_pkg::STAT_EMPTY, '0, 0);
		add_chk(rde_pkg::REQ_READ_FRONT, '0, '0, rde_pkg::STAT_EMPTY, '0, 0);
		add_chk(rde_pkg::REQ_WRITE_BACK, '1, '0, rde_pkg::STAT_EMPTY, '0, 0);
		// two elements, data extremes, reads from both ends
		add_chk(rde_pkg::REQ_PUSH_FRONT, '1, '0, rde_pkg::STAT_OK, '0, 1);
		add_chk(rde_pkg::REQ_PUSH_BACK, '0, '1, rde_pkg::STAT_OK, '0, 2);
		add_chk(rde_pkg::REQ_READ_FRONT, '0, '0, rde_pkg::STAT_OK, '1, 2);
		add_chk(rde_pkg::REQ_READ_BACK, '0, 10'd1, rde_pkg::STAT_OK, '1, 2);
		// offsets at and past the length, then an in-range write, read and pops
		add_chk(rde_pkg::REQ_READ_FRONT, '0, 10'd2, rde_pkg::STAT_RANGE, '0, 2);
		add_chk(rde_pkg::REQ_WRITE_BACK, '1, '1, rde_pkg::STAT_RANGE, '0, 2);
		add_op(rde_pkg::REQ_WRITE_FRONT, 64'h0123_4567_89ab_cdef, 10'd1);
		add_op(rde_pkg::REQ_READ_BACK, '0, '0);
		add_op(rde_pkg::REQ_POP_BACK, '0, '0);
		add_op(rde_pkg::REQ_POP_FRONT, '0, '0);
		// clear keeps nothing visible
		add_op(rde_pkg::REQ_PUSH_BACK, 64'h8000_0000_0000_0001, '0);
		add_chk(rde_pkg::REQ_CLEAR, '0, '0, rde_pkg::STAT_OK, '0, 0);
		// zero capacity acts as one entry: later pushes are dropped
		add_cfg('0);
		add_chk(rde_pkg::REQ_PUSH_BACK, 64'h5a5a_a5a5_5a5a_a5a5, '0,
			rde_pkg::STAT_OK, '0, 1);
		add_chk(rde_pkg::REQ_PUSH_FRONT, 64'hdead_beef_0000_ffff, '0,
			rde_pkg::STAT_FULL, '0, 1);
		add_chk(rde_pkg::REQ_PUSH_BACK, 64'h1111_2222_3333_4444, '0,
			rde_pkg::STAT_FULL, '0, 1);
		add_op(rde_pkg::REQ_POP_FRONT, '0, '0);
		// oversized capacity acts as the full store; front push wraps
		add_cfg('1);
		add_op(rde_pkg::REQ_PUSH_FRONT, 64'hfedc_ba98_7654_3210, '0);
		add_op(rde_pkg::REQ_PUSH_FRONT, 64'h0f0f_f0f0_3c3c_c3c3, '0);
		add_op(rde_pkg::REQ_READ_BACK, '0, '0);
		add_op(rde_pkg::REQ_POP_BACK, '0, '0);

		phase_caps = '{2, 1024, 1, 2047, 0, 3, 13, 1024, 5, 2};
		phase_caps[8] = $urandom_range(4, 64);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				write_capacity(dir_rows[i].cap_val);
			end else begin
				send_request(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
				directed_count++;
			end
		end

		// random phases: fill then drain, under a new capacity each time
		for (ph = 0; ph < PHASES; ph++) begin
			write_capacity(rde_pkg::CAP_W'(phase_caps[ph]));
			quiet = (ph == 3);
			if (ph == 1) hold_asked++;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				push_pct = (n < PHASE_ITEMS / 2) ? 60 : 20;
				pop_pct  = (n < PHASE_ITEMS / 2) ? 15 : 45;
				r = $urandom_range(0, 99);
				if (r < push_pct)
					code = $urandom_range(0, 1) ? rde_pkg::REQ_PUSH_FRONT :
						rde_pkg::REQ_PUSH_BACK;
				else if (r < push_pct + pop_pct)
					code = $urandom_range(0, 1) ? rde_pkg::REQ_POP_FRONT :
						rde_pkg::REQ_POP_BACK;
				else if (r < 98) begin
					case ($urandom_range(0, 3))
						0: code = rde_pkg::REQ_READ_FRONT;
						1: code = rde_pkg::REQ_WRITE_FRONT;
						2: code = rde_pkg::REQ_READ_BACK;
						default: code = rde_pkg::REQ_WRITE_BACK;
					endcase
				end else
					code = rde_pkg::REQ_CLEAR;
				case ($urandom_range(0, 7))
					0: d = '0;
					1: d = '1;
					default: d = {$urandom, $urandom};
				endcase
				r = $urandom_range(0, 99);
				if (shadow_count > 0 && r < 80)
					off = rde_pkg::OFF_W'($urandom_range(0, shadow_count - 1));
				else if (r < 90)
					off = (shadow_count > 1023) ? '1 : rde_pkg::OFF_W'(shadow_count);
				else
					off = rde_pkg::OFF_W'($urandom_range(0, 1023));
				item.req_type = code;
				item.data_in  = d;
				item.offset   = off;
				send_request(item, 1'b0, no_rsp);
			end
			quiet = 1'b0;
		end

		drain_responses();
		if (awaited_responses.size() != 0)
			flag_mismatch("results never returned", 64'(awaited_responses.size()), '0);

		$display("covered %0d requests (%0d directed), %0d results checked, %0d capacity writes",
			sent_count, directed_count, checked_count, cfg_count);
		$display("status mix: %0d full, %0d empty, %0d out of range; %0d receiver hold-offs",
			full_seen, empty_seen, range_seen, hold_served);
		if (error_count == 0)
			$display("ring_deque_engine_unit regression: pass");
		else
			$display("ring_deque_engine_unit regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/rde_pkg.sv
rtl/core/rde_ctrl.sv
rtl/core/rde_datapath.sv
rtl/core/ring_deque_engine_unit.sv
rtl/core/rde_checker.sv
tb/ring_deque_engine_unit_tb.sv
